[hdl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared constants and types for the solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int OUT_W  = 48;
    localparam int LANES  = 4;
    localparam int FLAG_W = 3;

    // Divider lanes, in the order the results leave on the output word.
    localparam int LANE_AXIS   = 0;
    localparam int LANE_VERTEX = 1;
    localparam int LANE_FIRST  = 2;
    localparam int LANE_SECOND = 3;

    typedef struct packed {
        logic degenerate;
        logic opens_up;
        logic is_complex;
    } qrs_flags_t;

endpackage

[hdl/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined square root
// Floored integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2*ROOT_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [ROOT_W-1:0]       root,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0] valid_reg;
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              v_src;
        logic [RAD_W-1:0]  rad_src;
        logic [REM_W-1:0]  rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [SIDE_W-1:0] side_src;
        logic [REM_W+1:0]  rem_next;
        logic [REM_W+1:0]  trial;

        if (k == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign rad_src  = radicand;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = side_in;
        end
        else
        begin : g_rest
            assign v_src    = valid_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        // Bring down the next bit pair and try subtracting 4*root + 1.
        assign rem_next = {rem_src, rad_src[RAD_W-1 -: 2]};
        assign trial    = {2'b00, root_src, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_src << 2;
                side_reg[k] <= side_src;
                if (rem_next >= trial)
                begin
                    rem_reg[k]  <= REM_W'(rem_next - trial);
                    root_reg[k] <= {root_src[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_next[REM_W-1:0];
                    root_reg[k] <= {root_src[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

[hdl/qrs_div.sv]
// ----------------------------------------------------------------------------
// Pipelined divider lanes
// Unsigned restoring division, one quotient bit per stage, four lanes abreast.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 18,
    parameter int SIDE_W = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [qrs_pkg::LANES-1:0][NUM_W-1:0] num_mag,
    input  logic [qrs_pkg::LANES-1:0][DEN_W-1:0] den_mag,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_valid,
    output logic [qrs_pkg::LANES-1:0][NUM_W-1:0] quo,
    output logic [SIDE_W-1:0]                    side_out
);

    logic [NUM_W-1:0]  valid_reg;
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [NUM_W-1:0]  acc_reg  [NUM_W][qrs_pkg::LANES];
    logic [DEN_W-1:0]  rem_reg  [NUM_W][qrs_pkg::LANES];
    logic [DEN_W-1:0]  den_reg  [NUM_W][qrs_pkg::LANES];

    genvar k, l;
    for (k = 0; k < NUM_W; k++)
    begin : g_stage
        logic              v_src;
        logic [SIDE_W-1:0] side_src;

        if (k == 0)
        begin : g_first_ctl
            assign v_src    = in_valid;
            assign side_src = side_in;
        end
        else
        begin : g_rest_ctl
            assign v_src    = valid_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[k] <= side_src;
        end

        for (l = 0; l < qrs_pkg::LANES; l++)
        begin : g_lane
            logic [NUM_W-1:0] acc_src;
            logic [DEN_W-1:0] rem_src;
            logic [DEN_W-1:0] den_src;
            logic [DEN_W:0]   rem_next;

            if (k == 0)
            begin : g_first
                assign acc_src = num_mag[l];
                assign rem_src = '0;
                assign den_src = den_mag[l];
            end
            else
            begin : g_rest
                assign acc_src = acc_reg[k-1][l];
                assign rem_src = rem_reg[k-1][l];
                assign den_src = den_reg[k-1][l];
            end

            // The numerator shifts out at the top while quotient bits enter below.
            assign rem_next = {rem_src, acc_src[NUM_W-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k][l] <= den_src;
                    if (rem_next >= {1'b0, den_src})
                    begin
                        rem_reg[k][l] <= DEN_W'(rem_next - {1'b0, den_src});
                        acc_reg[k][l] <= {acc_src[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k][l] <= rem_next[DEN_W-1:0];
                        acc_reg[k][l] <= {acc_src[NUM_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    for (l = 0; l < qrs_pkg::LANES; l++)
    begin : g_out
        assign quo[l] = acc_reg[NUM_W-1][l];
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

[hdl/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// Quadratic root solver
// Axis, vertex and roots of a*x^2 + b*x + c in signed fixed point.
// ----------------------------------------------------------------------------
// One coefficient word is taken every cycle that the output is not stalled, and one
// result word leaves for each, in order. Two stages form the discriminant, the square
// root produces one root bit per stage, one stage builds the numerators, the four
// divider lanes produce one quotient bit per stage, and a final stage signs and
// saturates the results. A stall on the output holds the whole pipeline, and nothing
// is lost.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // coef_a, coef_b, coef_c (from bit 0 up), zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // axis_x, vertex_y, first_value, second_value (from bit 0 up)
    output logic [qrs_pkg::LANES*qrs_pkg::OUT_W-1:0]  m_tdata,
    // is_complex, opens_up, degenerate (from bit 0 up)
    output logic [qrs_pkg::FLAG_W-1:0]                m_tuser
);

    localparam int CW     = COEF_WIDTH;
    localparam int FB     = FRAC_BITS;
    localparam int DM     = 2 * CW + 1;
    localparam int DW     = 2 * CW + 3;
    localparam int RB     = CW + FB + 1;
    localparam int NW     = 2 * CW + 1 + FB;
    localparam int DNW    = CW + 2;
    localparam int OW     = qrs_pkg::OUT_W;
    localparam int EW     = (NW + 1 > OW) ? NW + 1 : OW;
    localparam int SIDE1  = 2 * CW + DM + 1;
    localparam int SIDE2  = qrs_pkg::FLAG_W + qrs_pkg::LANES;

    localparam logic signed [EW-1:0] SAT_HI = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: products.
    logic                   v1_reg;
    logic signed [CW-1:0]   a1_reg, b1_reg;
    logic signed [2*CW-1:0] bb1_reg, ac1_reg;
    logic signed [CW-1:0]   a_in, b_in, c_in;

    assign a_in = s_tdata[CW-1:0];
    assign b_in = s_tdata[2*CW-1:CW];
    assign c_in = s_tdata[3*CW-1:2*CW];

    // Stage 2: discriminant as sign and magnitude.
    logic                 v2_reg;
    logic signed [CW-1:0] a2_reg, b2_reg;
    logic [DM-1:0]        dmag2_reg;
    logic                 dneg2_reg;
    logic signed [DW-1:0] disc_next;

    assign disc_next = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a_in;
            b1_reg    <= b_in;
            bb1_reg   <= b_in * b_in;
            ac1_reg   <= a_in * c_in;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            dneg2_reg <= disc_next[DW-1];
            dmag2_reg <= disc_next[DW-1] ? DM'(-disc_next) : disc_next[DM-1:0];
        end
    end

    // Square root of |disc| * 2^(2*FB).
    logic [2*RB-1:0] radicand;
    logic [SIDE1-1:0] side1_in, side1_out;
    logic             vs;
    logic [RB-1:0]    root;

    assign radicand = {1'b0, dmag2_reg, {(2*FB){1'b0}}};
    assign side1_in = {a2_reg, b2_reg, dmag2_reg, dneg2_reg};

    qrs_sqrt #(
        .ROOT_W (RB),
        .SIDE_W (SIDE1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .radicand  (radicand),
        .side_in   (side1_in),
        .out_valid (vs),
        .root      (root),
        .side_out  (side1_out)
    );

    // Stage 3: numerators and denominators, as sign and magnitude.
    logic signed [CW-1:0] a_s, b_s;
    logic [DM-1:0]        dmag_s;
    logic                 dneg_s;
    assign {a_s, b_s, dmag_s, dneg_s} = side1_out;

    logic signed [NW:0]  nb, s_ext, dterm;
    logic signed [NW:0]  num [qrs_pkg::LANES];
    logic [CW-1:0]       amag;
    qrs_pkg::qrs_flags_t flags_next;

    assign nb    = -((NW+1)'(b_s) <<< FB);
    assign s_ext = (NW+1)'(root);
    assign dterm = (NW+1)'({dmag_s, {FB{1'b0}}});
    assign amag  = a_s[CW-1] ? CW'(-a_s) : a_s;

    always_comb
    begin
        num[qrs_pkg::LANE_AXIS]   = nb;
        num[qrs_pkg::LANE_VERTEX] = dneg_s ? dterm : -dterm;
        num[qrs_pkg::LANE_FIRST]  = dneg_s ? nb : nb + s_ext;
        num[qrs_pkg::LANE_SECOND] = dneg_s ? s_ext : nb - s_ext;
        flags_next.is_complex = dneg_s;
        flags_next.opens_up   = !a_s[CW-1] && (a_s != '0);
        flags_next.degenerate = (a_s == '0);
    end

    logic                                 v3_reg;
    logic [qrs_pkg::LANES-1:0][NW-1:0]    nmag3_reg;
    logic [qrs_pkg::LANES-1:0][DNW-1:0]   dmag3_reg;
    logic [qrs_pkg::LANES-1:0]            qneg3_reg;
    qrs_pkg::qrs_flags_t                  flags3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= vs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags3_reg <= flags_next;
            for (int i = 0; i < qrs_pkg::LANES; i++)
            begin
                nmag3_reg[i] <= num[i][NW] ? NW'(-num[i]) : num[i][NW-1:0];
                qneg3_reg[i] <= num[i][NW] ^ a_s[CW-1];
                if (i == qrs_pkg::LANE_VERTEX)
                    dmag3_reg[i] <= {amag, 2'b00};
                else
                    dmag3_reg[i] <= {1'b0, amag, 1'b0};
            end
        end
    end

    // Division lanes.
    logic [SIDE2-1:0]                  side2_in, side2_out;
    logic                              vd;
    logic [qrs_pkg::LANES-1:0][NW-1:0] quo;
    qrs_pkg::qrs_flags_t               flags_d;
    logic [qrs_pkg::LANES-1:0]         qneg_d;

    assign side2_in         = {flags3_reg, qneg3_reg};
    assign {flags_d, qneg_d} = side2_out;

    qrs_div #(
        .NUM_W  (NW),
        .DEN_W  (DNW),
        .SIDE_W (SIDE2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .num_mag   (nmag3_reg),
        .den_mag   (dmag3_reg),
        .side_in   (side2_in),
        .out_valid (vd),
        .quo       (quo),
        .side_out  (side2_out)
    );

    // Output stage: apply sign, saturate, clear for a zero leading coefficient.
    logic [qrs_pkg::LANES-1:0][OW-1:0] res_next;
    logic signed [EW-1:0]              qext [qrs_pkg::LANES];

    always_comb
    begin
        for (int i = 0; i < qrs_pkg::LANES; i++)
        begin
            qext[i] = qneg_d[i] ? -EW'(quo[i]) : EW'(quo[i]);
            if (flags_d.degenerate)
                res_next[i] = '0;
            else if (qext[i] > SAT_HI)
                res_next[i] = SAT_HI[OW-1:0];
            else if (qext[i] < SAT_LO)
                res_next[i] = SAT_LO[OW-1:0];
            else
                res_next[i] = qext[i][OW-1:0];
        end
    end

    logic                              out_valid_reg;
    logic [qrs_pkg::LANES-1:0][OW-1:0] res_reg;
    qrs_pkg::qrs_flags_t               flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            if (flags_d.degenerate)
                flags_reg <= '{degenerate: 1'b1, opens_up: 1'b0, is_complex: 1'b0};
            else
                flags_reg <= flags_d;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = flags_reg;

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags_reg.degenerate |-> (res_reg == '0) && !flags_reg.is_complex
            && !flags_reg.opens_up)
        else $error("degenerate result carries non-zero outputs");

    a_complex_real_part: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags_reg.is_complex |->
            res_reg[qrs_pkg::LANE_FIRST] == res_reg[qrs_pkg::LANE_AXIS])
        else $error("complex real part differs from axis");

    a_roots_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags_reg.opens_up && !flags_reg.is_complex |->
            $signed(res_reg[qrs_pkg::LANE_FIRST]) >= $signed(res_reg[qrs_pkg::LANE_SECOND]))
        else $error("roots out of order for upward opening parabola");

endmodule

[dv/tb_quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient words through the stream slave port, computes the axis,
// vertex and roots of each polynomial independently, and compares every result
// word in order, printing mismatches field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;

    localparam int CW   = 16;
    localparam int FB   = 16;
    localparam int SD_W = ((3*CW+7)/8)*8;
    localparam int OW   = qrs_pkg::OUT_W;
    localparam int LATENCY = 4 + (CW + FB + 1) + (2*CW + FB + 1);
    localparam int N_RANDOM = 1530;

    typedef struct packed {
        logic [OW-1:0]       second_value;
        logic [OW-1:0]       first_value;
        logic [OW-1:0]       vertex_y;
        logic [OW-1:0]       axis_x;
        qrs_pkg::qrs_flags_t flags;
    } roots_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   known;
        roots_t               want;
    } coef_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [SD_W-1:0]                       s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [qrs_pkg::LANES*OW-1:0]          m_tdata;
    logic [qrs_pkg::FLAG_W-1:0]            m_tuser;

    roots_t    roots_due[$];
    int        mismatches;
    int        words_in;
    int        words_out;
    int        send_idle_pct;
    int        recv_idle_pct;
    coef_row_t sweep[$];

    quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Floor of sqrt(m) with FB fraction bits: the bit pairs of m come first,
    // then FB pairs of zeros.
    function automatic longint unsigned root_floor(longint unsigned m);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int i = 62; i >= -2*FB; i -= 2)
        begin
            rem = (rem << 2) | ((i >= 0) ? ((m >> i) & 64'd3) : 64'd0);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic [OW-1:0] quot_sat(longint num, longint den);
        longint q;
        longint hi;
        hi = (64'sd1 <<< (OW-1)) - 1;
        q = num / den;
        if (q > hi)
            q = hi;
        if (q < -hi - 1)
            q = -hi - 1;
        return q[OW-1:0];
    endfunction

    function automatic roots_t solve_quadratic(logic signed [CW-1:0] ca,
                                               logic signed [CW-1:0] cb,
                                               logic signed [CW-1:0] cc);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint nb;
        longint s;
        a = longint'(ca);
        b = longint'(cb);
        c = longint'(cc);
        r = '0;
        if (a == 0)
        begin
            r.flags.degenerate = 1'b1;
            return r;
        end
        disc = b*b - 4*a*c;
        nb = -b * (64'sd1 <<< FB);
        r.axis_x = quot_sat(nb, 2*a);
        r.vertex_y = quot_sat(-disc * (64'sd1 <<< FB), 4*a);
        if (disc < 0)
        begin
            s = longint'(root_floor(-disc));
            r.first_value = r.axis_x;
            r.second_value = quot_sat(s, 2*a);
            r.flags.is_complex = 1'b1;
        end
        else
        begin
            s = longint'(root_floor(disc));
            r.first_value = quot_sat(nb + s, 2*a);
            r.second_value = quot_sat(nb - s, 2*a);
        end
        r.flags.opens_up = (a > 0);
        return r;
    endfunction

    // The valid line only drops while the sender idles, so it never takes two
    // assignments at one edge.
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, bit known, roots_t want);
        roots_t model;
        model = solve_quadratic(a, b, c);
        if (known && model != want)
            $display("Table row a=%0d b=%0d c=%0d disagrees with the predictor",
                     a, b, c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= SD_W'({c, b, a});
        roots_due.push_back(known ? want : model);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_in++;
    endtask

    function automatic coef_row_t row(int a, int b, int c);
        coef_row_t t;
        t.a = CW'(a);
        t.b = CW'(b);
        t.c = CW'(c);
        t.known = 1'b0;
        t.want = '0;
        return t;
    endfunction

    function automatic coef_row_t flat_row(int b, int c);
        coef_row_t t;
        t = row(0, b, c);
        t.known = 1'b1;
        t.want.flags.degenerate = 1'b1;
        return t;
    endfunction

    // x^2 - 1: roots +1 and -1, axis 0, vertex -1.
    function automatic coef_row_t unit_row();
        coef_row_t t;
        t = row(1, 0, -1);
        t.known = 1'b1;
        t.want.vertex_y = -(48'sd1 <<< FB);
        t.want.first_value = 48'sd1 <<< FB;
        t.want.second_value = -(48'sd1 <<< FB);
        t.want.flags.opens_up = 1'b1;
        return t;
    endfunction

    // Result side: stall at random and check each word against the oldest one due.
    always @(posedge clk)
    begin
        roots_t got;
        roots_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tuser};
                words_out++;
                if (roots_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %h", got);
                end
                else
                begin
                    want = roots_due.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch (expected/actual): axis %h/%h ",
                                      "vertex %h/%h first %h/%h second %h/%h ",
                                      "flags %b/%b"},
                                     want.axis_x, got.axis_x, want.vertex_y, got.vertex_y,
                                     want.first_value, got.first_value,
                                     want.second_value, got.second_value,
                                     want.flags, got.flags);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        coef_row_t t;
        int mode;
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        send_idle_pct = 35;
        recv_idle_pct = 48;

        sweep.push_back(flat_row(0, 0));
        sweep.push_back(flat_row(-32768, 32767));
        sweep.push_back(flat_row(32767, -32768));
        sweep.push_back(unit_row());
        sweep.push_back(row(1, 0, 1));
        sweep.push_back(row(-1, 0, 1));
        sweep.push_back(row(-1, 0, -1));
        sweep.push_back(row(1, 2, 1));
        sweep.push_back(row(32767, 32767, 32767));
        sweep.push_back(row(32767, -32768, -32768));
        sweep.push_back(row(-32768, -32768, -32768));
        sweep.push_back(row(-32768, 32767, 32767));
        sweep.push_back(row(-32768, 0, 32767));
        sweep.push_back(row(32767, 0, -32768));
        sweep.push_back(row(1, -32768, 32767));
        sweep.push_back(row(-1, 32767, -32768));
        sweep.push_back(row(1, 32767, -32768));
        sweep.push_back(row(3, 5, 7));
        sweep.push_back(row(-3, 5, 7));
        sweep.push_back(row(-7, -3, -2));
        sweep.push_back(row(2, -1, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (sweep[i])
            send_coefs(sweep[i].a, sweep[i].b, sweep[i].c, sweep[i].known,
                       sweep[i].want);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM/3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 35;
            end
            if (n == 2*N_RANDOM/3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mode = $urandom_range(3);
            // Small coefficients give exact roots and zero discriminants often.
            if (mode == 0)
                t = row($signed($urandom_range(16)) - 8, $signed($urandom_range(16)) - 8,
                        $signed($urandom_range(16)) - 8);
            else
                t = row($urandom, $urandom, $urandom);
            if ($urandom_range(39) == 0)
                t.a = '0;
            send_coefs(t.a, t.b, t.c, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (roots_due.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d coefficient words and checked %0d result words,", words_in,
                 words_out);
        $display("covering real, repeated, complex and flat cases; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && roots_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d results still due.", roots_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
